>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Sizes, status and command codes, request/result structs, and the
// circular slot address helper used by the controller.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PRIO_BITS = 4;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_EMPTY = STAT_W'(2);

  typedef struct packed {
    logic                 cmd;
    logic [TAG_BITS-1:0]  tag_in;
    logic [PRIO_BITS-1:0] priority_in;
  } spq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [TAG_BITS-1:0]  tag_out;
    logic [PRIO_BITS-1:0] priority_out;
    logic [OCC_W-1:0]     occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } spq_entry_t;

  // Slot memory access from the controller
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    spq_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } spq_mem_req_t;

  // Physical slot of logical position k behind the head, wrapping at DEPTH
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] k);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + (IDX_W+1)'(k);
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, FIFO among equal priorities
// Each request gives exactly one result, shown for one cycle with
// out_valid; the receiver cannot stall, so it must take every strobe.
// A request is taken when start is high and busy is low. Full enqueue and
// empty dequeue answer in the next cycle without raising busy. A dequeue
// holds busy through S_DEQ, which takes the registered head slot. An
// enqueue alternates S_ENQ_RD and S_ENQ_CMP per moved entry and ends in
// S_ENQ_RD when it lands at the front, else in S_ENQ_CMP. Either way the
// result strobe rises as busy falls. Each moved entry needs a read and a
// compare state, as the slot memory has one read port with registered data.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  spq_pkg::spq_in_t             in_req,
  output logic                         out_valid,
  output spq_pkg::spq_out_t            out_result,
  input  logic                         cfg_we,
  input  logic [spq_pkg::CAP_W-1:0]    cfg_wdata
);

  logic [spq_pkg::CAP_W-1:0] cap_r;
  logic [spq_pkg::LIM_W-1:0] limit;
  spq_pkg::spq_mem_req_t     mem_req;
  spq_pkg::spq_entry_t       rd_data;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= spq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Saturate the limit at the slot count
  always_comb begin
    if (spq_pkg::LIM_W'(cap_r) > spq_pkg::LIM_W'(spq_pkg::DEPTH)) begin
      limit = spq_pkg::LIM_W'(spq_pkg::DEPTH);
    end else begin
      limit = spq_pkg::LIM_W'(cap_r);
    end
  end

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .limit      (limit),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  spq_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

>>> rtl/spq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store: slot memory
// One write port and one read port; read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module spq_store (
  input  logic                  clk,
  input  spq_pkg::spq_mem_req_t mem_req,
  output spq_pkg::spq_entry_t   rd_data
);

  spq_pkg::spq_entry_t mem [spq_pkg::DEPTH];
  spq_pkg::spq_entry_t rd_data_r;

  // Write the addressed slot
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: queue sequencer
// Keeps head pointer and count of a circular slot buffer. Dequeue reads
// the head slot; enqueue walks back from the tail, moving lower-priority
// entries one slot later until the insertion point is found.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  spq_pkg::spq_in_t             in_req,
  input  logic [spq_pkg::LIM_W-1:0]    limit,
  output spq_pkg::spq_mem_req_t        mem_req,
  input  spq_pkg::spq_entry_t          rd_data,
  output logic                         out_valid,
  output spq_pkg::spq_out_t            out_result
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_DEQ     = 2'd1;
  localparam logic [1:0] S_ENQ_RD  = 2'd2;
  localparam logic [1:0] S_ENQ_CMP = 2'd3;

  logic [1:0]                  state_r,   state_nxt;
  logic [spq_pkg::IDX_W-1:0]   head_r,    head_nxt;
  logic [spq_pkg::CNT_W-1:0]   count_r,   count_nxt;
  logic [spq_pkg::CNT_W-1:0]   k_r,       k_nxt;
  spq_pkg::spq_entry_t         new_r,     new_nxt;
  logic                        out_valid_r, out_valid_nxt;
  spq_pkg::spq_out_t           out_result_r, out_result_nxt;

  // Sequence the request
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    new_nxt        = new_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    mem_req.we     = 1'b0;
    mem_req.waddr  = head_r;
    mem_req.wdata  = new_r;
    mem_req.raddr  = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_result_nxt.tag_out      = '0;
          out_result_nxt.priority_out = '0;
          out_result_nxt.occupancy    = spq_pkg::OCC_W'(count_r);
          if (in_req.cmd == spq_pkg::CMD_ENQ) begin
            if (spq_pkg::LIM_W'(count_r) >= limit) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = spq_pkg::ST_FULL;
            end else begin
              new_nxt.tag  = in_req.tag_in;
              new_nxt.prio = in_req.priority_in;
              k_nxt        = count_r;
              state_nxt    = S_ENQ_RD;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.status = spq_pkg::ST_EMPTY;
            end else begin
              // head slot is read this cycle
              state_nxt = S_DEQ;
            end
          end
        end
      end

      S_DEQ: begin
        out_valid_nxt               = 1'b1;
        out_result_nxt.status       = spq_pkg::ST_DONE;
        out_result_nxt.tag_out      = rd_data.tag;
        out_result_nxt.priority_out = rd_data.prio;
        out_result_nxt.occupancy    = spq_pkg::OCC_W'(count_r - 1'b1);
        head_nxt                    = spq_pkg::slot_addr(head_r, spq_pkg::CNT_W'(1));
        count_nxt                   = count_r - 1'b1;
        state_nxt                   = S_IDLE;
      end

      S_ENQ_RD: begin
        if (k_r == '0) begin
          // reached the front: place the new entry there
          mem_req.we    = 1'b1;
          mem_req.waddr = head_r;
          mem_req.wdata = new_r;
          out_valid_nxt               = 1'b1;
          out_result_nxt.status       = spq_pkg::ST_DONE;
          out_result_nxt.tag_out      = '0;
          out_result_nxt.priority_out = '0;
          out_result_nxt.occupancy    = spq_pkg::OCC_W'(count_r + 1'b1);
          count_nxt                   = count_r + 1'b1;
          state_nxt                   = S_IDLE;
        end else begin
          mem_req.raddr = spq_pkg::slot_addr(head_r, k_r - 1'b1);
          state_nxt     = S_ENQ_CMP;
        end
      end

      S_ENQ_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = spq_pkg::slot_addr(head_r, k_r);
        if (rd_data.prio >= new_r.prio) begin
          // insert behind entries of equal or higher priority
          mem_req.wdata               = new_r;
          out_valid_nxt               = 1'b1;
          out_result_nxt.status       = spq_pkg::ST_DONE;
          out_result_nxt.tag_out      = '0;
          out_result_nxt.priority_out = '0;
          out_result_nxt.occupancy    = spq_pkg::OCC_W'(count_r + 1'b1);
          count_nxt                   = count_r + 1'b1;
          state_nxt                   = S_IDLE;
        end else begin
          // shift the lower-priority entry one slot back
          mem_req.wdata = rd_data;
          k_nxt         = k_r - 1'b1;
          state_nxt     = S_ENQ_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    new_r        <= new_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

>>> tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Feeds enqueue and dequeue requests in random bursts, tracks the expected
// queue contents in a local sorted-array predictor, and compares each result
// strobe field by field. Capacity is reprogrammed between idle phases.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  spq_pkg::spq_in_t              in_req;
  logic                          out_valid;
  spq_pkg::spq_out_t             out_result;
  logic                          cfg_we;
  logic [spq_pkg::CAP_W-1:0]     cfg_wdata;

  // Predictor state: held entries, front at slot 0
  logic [spq_pkg::TAG_BITS-1:0]  held_tag [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_BITS-1:0] held_prio [spq_pkg::DEPTH];
  int unsigned                   held_count = 0;
  int unsigned                   cap_setting = 16;

  spq_pkg::spq_in_t              req_backlog [$];
  spq_pkg::spq_out_t             due_replies [$];
  int unsigned                   reqs_queued = 0;
  int unsigned                   reqs_taken = 0;
  int unsigned                   mismatches = 0;
  int unsigned                   cycle_count = 0;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the predicted queue and return its expected result
  function automatic spq_pkg::spq_out_t predict_queue_op(spq_pkg::spq_in_t req);
    spq_pkg::spq_out_t res;
    int unsigned       lim;
    int unsigned       pos;
    res = '0;
    res.status = spq_pkg::ST_DONE;
    lim = (cap_setting > spq_pkg::DEPTH) ? spq_pkg::DEPTH : cap_setting;
    if (req.cmd == spq_pkg::CMD_ENQ) begin
      if (held_count >= lim) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] >= req.priority_in) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_tag[i]  = held_tag[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos]  = req.tag_in;
        held_prio[pos] = req.priority_in;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.tag_out      = held_tag[0];
        res.priority_out = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_tag[i-1]  = held_tag[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = spq_pkg::OCC_W'(held_count);
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic push_req(logic cmd, logic [spq_pkg::TAG_BITS-1:0] tag,
                          logic [spq_pkg::PRIO_BITS-1:0] prio);
    spq_pkg::spq_in_t r;
    r.cmd         = cmd;
    r.tag_in      = tag;
    r.priority_in = prio;
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  // Runs of enqueues and dequeues so the queue swings between empty and full
  task automatic push_random_phase(int unsigned n, int unsigned prio_hi);
    int unsigned left;
    int unsigned run_len;
    logic        run_cmd;
    left = n;
    while (left > 0) begin
      run_len = $urandom_range(1, 18);
      if (run_len > left) run_len = left;
      run_cmd = ($urandom_range(0, 1) == 0) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
      for (int i = 0; i < run_len; i++) begin
        // sprinkle an odd command into the run now and then
        if ($urandom_range(0, 9) == 0)
          push_req(~run_cmd, 16'($urandom),
                   spq_pkg::PRIO_BITS'($urandom_range(0, 15)));
        else
          push_req(run_cmd, 16'($urandom),
                   spq_pkg::PRIO_BITS'($urandom_range(0, prio_hi)));
      end
      left -= run_len;
    end
  endtask

  // Wait until every request is taken and answered, then let the block settle
  task automatic wait_idle();
    while (reqs_taken != reqs_queued || due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(logic [spq_pkg::CAP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cap_setting = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver: present requests in bursts with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_replies.push_back(predict_queue_op(in_req));
        reqs_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_req <= req_backlog.pop_front();
          start  <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expected result
  always @(posedge clk) begin
    spq_pkg::spq_out_t want;
    if (rst_n && out_valid) begin
      if (due_replies.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_result), 32'h0);
      end else begin
        want = due_replies.pop_front();
        if (out_result.status !== want.status)
          flag_mismatch("status", 32'(out_result.status), 32'(want.status));
        if (out_result.tag_out !== want.tag_out)
          flag_mismatch("tag_out", 32'(out_result.tag_out), 32'(want.tag_out));
        if (out_result.priority_out !== want.priority_out)
          flag_mismatch("priority_out", 32'(out_result.priority_out),
                        32'(want.priority_out));
        if (out_result.occupancy !== want.occupancy)
          flag_mismatch("occupancy", 32'(out_result.occupancy), 32'(want.occupancy));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Small capacity: empty dequeue, extreme fields, equal-priority order, full
    write_capacity(spq_pkg::CAP_W'(4));
    push_req(spq_pkg::CMD_DEQ, 16'h0000, 4'h0);
    push_req(spq_pkg::CMD_ENQ, 16'h0000, 4'h0);
    push_req(spq_pkg::CMD_ENQ, 16'hFFFF, 4'hF);
    push_req(spq_pkg::CMD_ENQ, 16'h1234, 4'hF);
    push_req(spq_pkg::CMD_ENQ, 16'hABCD, 4'h7);
    push_req(spq_pkg::CMD_ENQ, 16'h5555, 4'hF);
    for (int i = 0; i < 4; i++) push_req(spq_pkg::CMD_DEQ, 16'hFFFF, 4'hF);
    push_req(spq_pkg::CMD_DEQ, 16'hAAAA, 4'hA);
    wait_idle();

    // Zero capacity: every enqueue is refused
    write_capacity(spq_pkg::CAP_W'(0));
    push_req(spq_pkg::CMD_ENQ, 16'h8001, 4'h8);
    push_req(spq_pkg::CMD_DEQ, 16'h0000, 4'h0);
    wait_idle();

    // Capacity above depth, then lowered below the held count
    write_capacity(spq_pkg::CAP_W'(31));
    push_req(spq_pkg::CMD_ENQ, 16'h0101, 4'h3);
    push_req(spq_pkg::CMD_ENQ, 16'h0202, 4'h9);
    push_req(spq_pkg::CMD_ENQ, 16'h0303, 4'h3);
    push_req(spq_pkg::CMD_ENQ, 16'h0404, 4'h0);
    push_req(spq_pkg::CMD_ENQ, 16'h0505, 4'hC);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(2));
    push_req(spq_pkg::CMD_ENQ, 16'h0606, 4'hF);
    for (int i = 0; i < 4; i++) push_req(spq_pkg::CMD_DEQ, 16'h0000, 4'h0);
    push_req(spq_pkg::CMD_ENQ, 16'h0707, 4'h1);
    push_req(spq_pkg::CMD_DEQ, 16'h0000, 4'h0);
    push_req(spq_pkg::CMD_DEQ, 16'h0000, 4'h0);
    wait_idle();

    // Random phases across a spread of capacities
    write_capacity(spq_pkg::CAP_W'(16));
    push_random_phase(90, 15);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(1));
    push_random_phase(40, 15);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(31));
    push_random_phase(80, 3);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(8));
    push_random_phase(70, 15);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(17));
    push_random_phase(70, 1);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(5));
    push_random_phase(60, 15);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(0));
    push_random_phase(20, 15);
    wait_idle();
    write_capacity(spq_pkg::CAP_W'(16));
    push_random_phase(120, 7);
    wait_idle();

    if (due_replies.size() != 0)
      flag_mismatch("results never seen", 32'(due_replies.size()), 32'h0);
    if (mismatches == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_store.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
